@@ design/pvat_pkg.sv @@
`default_nettype none
package pvat_pkg;

	localparam int ANG_W  = 16;
	localparam int TURN_W = 16;
	localparam int VEL_W  = 17;
	localparam int ACC_W  = 18;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 112;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * VEL_W - 3 * ACC_W;

	localparam logic [TURN_W-1:0] FULL_TURN_RST = 16'd25736;

	localparam logic [1:0] CNT_TWO  = 2'd2;
	localparam logic [1:0] CNT_FULL = 2'd3;

	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_RESET = 1'b1;

	typedef enum logic [1:0] {
		PH_INACTIVE = 2'd0,
		PH_FRESH    = 2'd1,
		PH_ONE      = 2'd2
	} phase_t;

	typedef struct packed {
		logic vel_ok;
		logic acc_ok;
	} hist_flags_t;

endpackage
`default_nettype wire

@@ design/pose_velocity_acceleration_tracker.sv @@
// Pose velocity / acceleration tracker.
// Input beats (s_axis_*) carry one pose or a prediction reset event; tuser
// selects which (0 pose, 1 reset event). Every input beat yields exactly one
// output beat (m_axis_*) holding the first and second backward differences
// of x, y and heading over the last three poses; heading differences wrap
// by the full_turn register (written through cfg_we/cfg_wdata; the user
// must write it only while idle, which the block does not enforce).
// The input register captures a taken beat; a single combinational pass
// then fills the result register, which drives output valid.
// Throughput: 1 beat per cycle while the receiver keeps up; the window,
// counters and difference logic all settle in that one pass.
// Reset clears the pose count and reset phase and loads full_turn with
// two pi; the pose window itself holds no reset value and is gated by count.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more beat, then tready drops until the output
// drains.
`default_nettype none
module pose_velocity_acceleration_tracker #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// pos_x[15:0], pos_y[31:16], heading[47:32]
	input  wire logic [pvat_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// func
	input  wire logic                                 s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// vel_x[16:0], vel_y[33:17], vel_heading[50:34], acc_x[68:51],
	// acc_y[86:69], acc_heading[104:87], zero[111:105]
	output logic [pvat_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [pvat_pkg::TURN_W-1:0]          cfg_wdata
);
	import pvat_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int DW = (CW + 2 > ACC_W) ? CW + 2 : ACC_W;

	logic [TURN_W-1:0]       full_turn_q;
	logic                    v_s1, func_s1;
	logic signed [15:0]      px_s1, py_s1;
	logic signed [ANG_W-1:0] hd_s1;
	logic                    v_s2;
	logic                    adv, in_take;

	logic signed [CW-1:0]    px_c, py_c;
	logic signed [CW-1:0]    w0_x, w0_y, w1_x, w1_y, w2_x, w2_y;
	logic signed [ANG_W-1:0] w0_a, w1_a, w2_a;
	hist_flags_t             flags;

	logic signed [DW-1:0]    dx01, dx12, dy01, dy12, ddx, ddy;
	logic signed [VEL_W-1:0] vx_c, vy_c, va_c, va_prev;
	logic signed [ACC_W-1:0] ax_c, ay_c, aa_c;

	logic signed [VEL_W-1:0] vel_x_s2, vel_y_s2, vel_h_s2;
	logic signed [ACC_W-1:0] acc_x_s2, acc_y_s2, acc_h_s2;

	assign adv           = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_turn_q <= FULL_TURN_RST;
		end else if (cfg_we) begin
			full_turn_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= s_axis_tuser;
			px_s1   <= s_axis_tdata[15:0];
			py_s1   <= s_axis_tdata[31:16];
			hd_s1   <= s_axis_tdata[47:32];
		end
	end

	// sign extend or truncate the Q12.4 coordinates to the window width
	assign px_c = CW'(px_s1);
	assign py_c = CW'(py_s1);

	pvat_history #(.CW(CW)) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.func   (func_s1),
		.px     (px_c),
		.py     (py_c),
		.pa     (hd_s1),
		.w0_x   (w0_x),
		.w0_y   (w0_y),
		.w0_a   (w0_a),
		.w1_x   (w1_x),
		.w1_y   (w1_y),
		.w1_a   (w1_a),
		.w2_x   (w2_x),
		.w2_y   (w2_y),
		.w2_a   (w2_a),
		.flags  (flags)
	);

	always_comb begin
		dx01 = DW'(w0_x) - DW'(w1_x);
		dx12 = DW'(w1_x) - DW'(w2_x);
		dy01 = DW'(w0_y) - DW'(w1_y);
		dy12 = DW'(w1_y) - DW'(w2_y);
		ddx  = dx01 - dx12;
		ddy  = dy01 - dy12;
	end

	pvat_sat #(.IW(DW), .OW(VEL_W)) u_sat_vx (.d(dx01), .q(vx_c));
	pvat_sat #(.IW(DW), .OW(VEL_W)) u_sat_vy (.d(dy01), .q(vy_c));
	pvat_sat #(.IW(DW), .OW(ACC_W)) u_sat_ax (.d(ddx),  .q(ax_c));
	pvat_sat #(.IW(DW), .OW(ACC_W)) u_sat_ay (.d(ddy),  .q(ay_c));

	pvat_wrap u_wrap_new (.before_a(w1_a), .after_a(w0_a), .turn(full_turn_q), .diff(va_c));
	pvat_wrap u_wrap_old (.before_a(w2_a), .after_a(w1_a), .turn(full_turn_q), .diff(va_prev));

	assign aa_c = ACC_W'(va_c) - ACC_W'(va_prev);

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_x_s2 <= flags.vel_ok ? vx_c : '0;
			vel_y_s2 <= flags.vel_ok ? vy_c : '0;
			vel_h_s2 <= flags.vel_ok ? va_c : '0;
			acc_x_s2 <= flags.acc_ok ? ax_c : '0;
			acc_y_s2 <= flags.acc_ok ? ay_c : '0;
			acc_h_s2 <= flags.acc_ok ? aa_c : '0;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, acc_h_s2, acc_y_s2, acc_x_s2,
		vel_h_s2, vel_y_s2, vel_x_s2};

endmodule
`default_nettype wire

@@ design/pvat_wrap.sv @@
`default_nettype none
module pvat_wrap (
	input  wire logic signed [pvat_pkg::ANG_W-1:0]  before_a,
	input  wire logic signed [pvat_pkg::ANG_W-1:0]  after_a,
	input  wire logic        [pvat_pkg::TURN_W-1:0] turn,
	output logic signed [pvat_pkg::VEL_W-1:0]       diff
);
	import pvat_pkg::*;

	localparam int CW = ANG_W + 3;

	logic signed [CW-1:0] c1, c2, c3, t;
	logic        [CW-1:0] m1, m2, m3;
	logic signed [CW-1:0] pick;

	always_comb begin
		t  = signed'({3'b000, turn});
		c1 = CW'(after_a) - CW'(before_a);
		c2 = c1 + t;
		c3 = c1 - t;
		m1 = c1[CW-1] ? unsigned'(-c1) : unsigned'(c1);
		m2 = c2[CW-1] ? unsigned'(-c2) : unsigned'(c2);
		m3 = c3[CW-1] ? unsigned'(-c3) : unsigned'(c3);
		// d wins only when strictly smallest; +turn then wins only when strictly below -turn, so a +/-turn tie goes to -turn
		if (m1 < m2 && m1 < m3) begin
			pick = c1;
		end else if (m2 < m3) begin
			pick = c2;
		end else begin
			pick = c3;
		end
		// smallest magnitude never exceeds |d|, so it fits the velocity width
		diff = pick[VEL_W-1:0];
	end

endmodule
`default_nettype wire

@@ design/pvat_sat.sv @@
`default_nettype none
module pvat_sat #(
	parameter int IW = 18,
	parameter int OW = 17
) (
	input  wire logic signed [IW-1:0] d,
	output logic signed [OW-1:0]      q
);
	localparam logic signed [IW-1:0] HI = IW'((64'sd1 <<< (OW - 1)) - 64'sd1);
	localparam logic signed [IW-1:0] LO = -HI - IW'(1);

	always_comb begin
		if (d > HI) begin
			q = HI[OW-1:0];
		end else if (d < LO) begin
			q = LO[OW-1:0];
		end else begin
			q = d[OW-1:0];
		end
	end

endmodule
`default_nettype wire

@@ design/pvat_history.sv @@
`default_nettype none
module pvat_history #(
	parameter int CW = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               upd,
	input  wire logic                               func,
	input  wire logic signed [CW-1:0]               px,
	input  wire logic signed [CW-1:0]               py,
	input  wire logic signed [pvat_pkg::ANG_W-1:0]  pa,
	output logic signed [CW-1:0]                    w0_x,
	output logic signed [CW-1:0]                    w0_y,
	output logic signed [pvat_pkg::ANG_W-1:0]       w0_a,
	output logic signed [CW-1:0]                    w1_x,
	output logic signed [CW-1:0]                    w1_y,
	output logic signed [pvat_pkg::ANG_W-1:0]       w1_a,
	output logic signed [CW-1:0]                    w2_x,
	output logic signed [CW-1:0]                    w2_y,
	output logic signed [pvat_pkg::ANG_W-1:0]       w2_a,
	output pvat_pkg::hist_flags_t                   flags
);
	import pvat_pkg::*;

	logic signed [CW-1:0]    x0_q, x1_q, x2_q, y0_q, y1_q, y2_q;
	logic signed [ANG_W-1:0] a0_q, a1_q, a2_q;
	logic [1:0]              cnt_q, cnt_n;
	phase_t                  phase_q, phase_n;
	logic                    push;

	assign push = (func == FUNC_PUSH);

	// next window as seen by the item being finished this cycle
	always_comb begin
		if (push) begin
			w0_x = px;   w0_y = py;   w0_a = pa;
			w1_x = x0_q; w1_y = y0_q; w1_a = a0_q;
			w2_x = x1_q; w2_y = y1_q; w2_a = a1_q;
		end else begin
			w0_x = x0_q; w0_y = y0_q; w0_a = a0_q;
			w1_x = x1_q; w1_y = y1_q; w1_a = a1_q;
			w2_x = x2_q; w2_y = y2_q; w2_a = a2_q;
		end
	end

	always_comb begin
		cnt_n = cnt_q;
		if (push && cnt_q != CNT_FULL) begin
			cnt_n = cnt_q + 2'd1;
		end
		if (!push) begin
			phase_n = PH_FRESH;
		end else if (phase_q == PH_FRESH) begin
			phase_n = PH_ONE;
		end else begin
			phase_n = PH_INACTIVE;
		end
		flags.vel_ok = (cnt_n >= CNT_TWO) && (phase_n != PH_FRESH);
		flags.acc_ok = flags.vel_ok && (cnt_n == CNT_FULL) && (phase_n != PH_ONE);
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			x0_q <= w0_x; y0_q <= w0_y; a0_q <= w0_a;
			x1_q <= w1_x; y1_q <= w1_y; a1_q <= w1_a;
			x2_q <= w2_x; y2_q <= w2_y; a2_q <= w2_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			phase_q <= PH_INACTIVE;
		end else if (upd) begin
			cnt_q   <= cnt_n;
			phase_q <= phase_n;
		end
	end

endmodule
`default_nettype wire

@@ design/pvat_checker.sv @@
`default_nettype none
module pvat_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	input  wire logic                                 s_axis_tready,
	input  wire logic                                 m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	input  wire logic [pvat_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import pvat_pkg::*;

	logic [1:0] pend_q;
	logic       seen_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (out_beat) begin
				seen_q <= 1'b1;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= 2'd2) && (!out_beat || pend_q != 2'd0))
		else $error("output beats out of step with input beats");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !seen_q |-> m_axis_tdata == '0)
		else $error("first result after reset not all zero");

endmodule

bind pose_velocity_acceleration_tracker pvat_checker u_pvat_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ sim/pose_velocity_acceleration_tracker_test.sv @@
`default_nettype none
module pose_velocity_acceleration_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pvat_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASES      = 6;
	localparam int PHASE_BEATS = 130;
	localparam int SCRIPT_LEN  = 20;
	localparam int RING        = 8;

	// first member lands in the top bits, so vel_x sits at bit 0
	typedef struct packed {
		logic signed [ACC_W-1:0] acc_h;
		logic signed [ACC_W-1:0] acc_y;
		logic signed [ACC_W-1:0] acc_x;
		logic signed [VEL_W-1:0] vel_h;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_x;
	} motion_t;

	typedef struct {
		logic func;
		int   x, y, h;
		bit   typed;
		int   vx, vy, vh, ax, ay, ah;
	} script_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = FUNC_PUSH;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we        = 1'b0;
	logic [TURN_W-1:0]      cfg_wdata     = '0;

	// predictor state
	logic signed [15:0]     win_x [3];
	logic signed [15:0]     win_y [3];
	logic signed [15:0]     win_h [3];
	logic [1:0]             held  = '0;
	phase_t                 phase = PH_INACTIVE;
	logic [TURN_W-1:0]      turn  = FULL_TURN_RST;

	// predicted beats in flight, written at input beats and read at output beats
	motion_t                due_ring [RING];
	int                     wr_count = 0;
	int                     rd_count = 0;
	motion_t                seen, due;
	int                     fault_count = 0;
	int                     cycle_count = 0;
	int                     stall_pct   = 10;

	// opening rows start a fresh track at the coordinate extremes; a later pair of
	// poses steps the heading by exactly half a turn
	script_row_t script [SCRIPT_LEN] = '{
		'{FUNC_PUSH,       0,      0,      0, 1'b1,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,   32767, -32768,  32767, 1'b1,  32767, -32768,  7031,      0,     0,      0},
		'{FUNC_PUSH,  -32768,  32767, -32768, 1'b1, -65535, 65535, -39799, -98302, 98303, -46830},
		'{FUNC_RESET,      0,      0,      0, 1'b1,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,     100,    200,   1000, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,     130,    150,  13868, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,     160,    100,   1000, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_RESET,     -1,     -1,     -1, 1'b1,      0,     0,      0,      0,     0,      0},
		'{FUNC_RESET,      7,      7,      7, 1'b1,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,       0,      0,      0, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,      16,    -16,  25000, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,      -1,     -1, -25000, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,  -32768, -32768, -32768, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,   32767,  32767,  32767, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_RESET,  32767, -32768,      0, 1'b1,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,       5,      5,      5, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_RESET,      0,      0,      0, 1'b1,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,       6,      6,      6, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,       7,      7,      7, 1'b0,      0,     0,      0,      0,     0,      0},
		'{FUNC_PUSH,       8,      8,      8, 1'b0,      0,     0,      0,      0,     0,      0}
	};

	pose_velocity_acceleration_tracker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int abs_val(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp(input int v, input int w);
		int hi, lo;
		hi = (1 << (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// pick the shortest way around; d loses any tie, and a tie of +turn and -turn goes to -turn
	function automatic int heading_step(input int older, input int newer);
		int d, up, dn;
		d  = newer - older;
		up = d + int'(turn);
		dn = d - int'(turn);
		if (abs_val(d) < abs_val(up) && abs_val(d) < abs_val(dn)) return d;
		if (abs_val(up) < abs_val(dn)) return up;
		return dn;
	endfunction

	function automatic motion_t advance_window(input logic f, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] h);
		motion_t r;
		int      vx, vy, vh, ax, ay, ah;
		logic    vel_ok, acc_ok;
		vx = 0; vy = 0; vh = 0;
		ax = 0; ay = 0; ah = 0;
		if (f == FUNC_RESET) begin
			phase = PH_FRESH;
		end else begin
			win_x[2] = win_x[1]; win_x[1] = win_x[0]; win_x[0] = x;
			win_y[2] = win_y[1]; win_y[1] = win_y[0]; win_y[0] = y;
			win_h[2] = win_h[1]; win_h[1] = win_h[0]; win_h[0] = h;
			if (held != CNT_FULL)
				held = held + 2'd1;
			if (phase == PH_FRESH)
				phase = PH_ONE;
			else
				phase = PH_INACTIVE;
		end
		vel_ok = held >= CNT_TWO && phase != PH_FRESH;
		acc_ok = vel_ok && held == CNT_FULL && phase != PH_ONE;
		if (vel_ok) begin
			vx = int'(win_x[0]) - int'(win_x[1]);
			vy = int'(win_y[0]) - int'(win_y[1]);
			vh = heading_step(int'(win_h[1]), int'(win_h[0]));
		end
		if (acc_ok) begin
			ax = vx - (int'(win_x[1]) - int'(win_x[2]));
			ay = vy - (int'(win_y[1]) - int'(win_y[2]));
			ah = vh - heading_step(int'(win_h[2]), int'(win_h[1]));
		end
		r.vel_x = VEL_W'(clamp(vx, VEL_W));
		r.vel_y = VEL_W'(clamp(vy, VEL_W));
		r.vel_h = VEL_W'(clamp(vh, VEL_W));
		r.acc_x = ACC_W'(clamp(ax, ACC_W));
		r.acc_y = ACC_W'(clamp(ay, ACC_W));
		r.acc_h = ACC_W'(clamp(ah, ACC_W));
		return r;
	endfunction

	task automatic note_fault(input string name, input int want, input int got);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch %s: expected %0d, got %0d", name, want, got);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got)
			note_fault(name, want, got);
	endtask

	// hold valid across back-to-back beats; only a gap or a drain lowers it
	task automatic send_beat(input logic f, input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] h);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= f;
		s_axis_tdata  <= {h, y, x};
		do @(posedge clk); while (!s_axis_tready);
		due_ring[3'(wr_count)] = advance_window(f, x, y, h);
		wr_count++;
	endtask

	task automatic take_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		while (rd_count != wr_count)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pose_velocity_acceleration_tracker_test NOT OK");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = m_axis_tdata[$bits(motion_t)-1:0];
			if (rd_count == wr_count) begin
				note_fault("unexpected beat", 0, 1);
			end else begin
				due = due_ring[3'(rd_count)];
				rd_count++;
				check_field("vel_x", int'(due.vel_x), int'(seen.vel_x));
				check_field("vel_y", int'(due.vel_y), int'(seen.vel_y));
				check_field("vel_heading", int'(due.vel_h), int'(seen.vel_h));
				check_field("acc_x", int'(due.acc_x), int'(seen.acc_x));
				check_field("acc_y", int'(due.acc_y), int'(seen.acc_y));
				check_field("acc_heading", int'(due.acc_h), int'(seen.acc_h));
				check_field("pad", 0, int'(m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]));
			end
		end
	end

	initial begin
		int            gap_pct, pick, modes [3];
		logic          f;
		logic [15:0]   nx, ny, nh, lx, ly, lh, half;
		logic [15:0]   corners [4];
		logic [TURN_W-1:0] turns [PHASES];
		corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		turns   = '{16'd0, 16'hffff, FULL_TURN_RST, 16'd1, 16'd51472, 16'd0};
		turns[PHASES-1] = TURN_W'($urandom);
		modes   = '{0, 15, 40};
		lx = '0; ly = '0; lh = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 10;
		foreach (script[i]) begin
			take_gap(gap_pct);
			send_beat(script[i].func, 16'(script[i].x), 16'(script[i].y), 16'(script[i].h));
			if (script[i].typed) begin
				due_ring[3'(wr_count - 1)] = {ACC_W'(script[i].ah), ACC_W'(script[i].ay),
					ACC_W'(script[i].ax), VEL_W'(script[i].vh), VEL_W'(script[i].vy),
					VEL_W'(script[i].vx)};
			end
			if (script[i].func == FUNC_PUSH) begin
				lx = 16'(script[i].x); ly = 16'(script[i].y); lh = 16'(script[i].h);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			// drain fully before touching the register
			s_axis_tvalid <= 1'b0;
			wait_drain();
			repeat (4) @(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= turns[p];
			@(posedge clk);
			cfg_we    <= 1'b0;
			turn = turns[p];
			half = turn >> 1;

			if (p == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = modes[$urandom_range(0, 2)];
				stall_pct = modes[$urandom_range(0, 2)] / 3;
			end

			for (int n = 0; n < PHASE_BEATS; n++) begin
				take_gap(gap_pct);
				pick = $urandom_range(0, 99);
				f  = FUNC_PUSH;
				nx = 16'($urandom);
				ny = 16'($urandom);
				nh = 16'($urandom);
				if (pick < 10) begin
					f = FUNC_RESET;
				end else if (pick < 70) begin
					// smooth track with random jitter, or a heading step of about half a turn
					nx = lx + 16'($urandom_range(0, 64)) - 16'd32;
					ny = ly + 16'($urandom_range(0, 64)) - 16'd32;
					case ($urandom_range(0, 2))
						0: nh = lh + 16'($urandom_range(0, 600)) - 16'd300;
						1: nh = lh + half + 16'($urandom_range(0, 4)) - 16'd2;
						default: nh = lh - half + 16'($urandom_range(0, 4)) - 16'd2;
					endcase
				end else if (pick < 82) begin
					nx = corners[$urandom_range(0, 3)];
					ny = corners[$urandom_range(0, 3)];
					nh = corners[$urandom_range(0, 3)];
				end
				send_beat(f, nx, ny, nh);
				if (f == FUNC_PUSH) begin
					lx = nx; ly = ny; lh = nh;
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		wait_drain();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("pose_velocity_acceleration_tracker_test OK");
		else
			$display("pose_velocity_acceleration_tracker_test NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
